[rtl/core/xmr_pkg.sv]
package xmr_pkg;

	localparam int MAX_BLOCK_BYTES = 1024;
	localparam int ADDR_W = $clog2(MAX_BLOCK_BYTES);
	localparam int POS_W = 11;

	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_CAN = 8'h18;
	localparam logic [7:0] CH_C   = 8'h43;

	localparam logic [2:0] ACT_START = 3'd0;
	localparam logic [2:0] ACT_BYTE  = 3'd1;
	localparam logic [2:0] ACT_WAIT  = 3'd2;
	localparam logic [2:0] ACT_LOST  = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;

	localparam logic [2:0] SS_RUN    = 3'd0;
	localparam logic [2:0] SS_OK     = 3'd1;
	localparam logic [2:0] SS_CANCEL = 3'd2;
	localparam logic [2:0] SS_ERRORS = 3'd3;
	localparam logic [2:0] SS_LOST   = 3'd4;

	localparam logic [1:0] MODE_SUM = 2'd0;
	localparam logic [1:0] MODE_1K  = 2'd2;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_MAXERR = 2'd1;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] rx_byte;
		logic [9:0] read_index;
	} in_word_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        wait_long;
		logic        block_good;
		logic [2:0]  session_state;
		logic [7:0]  read_data;
		logic [15:0] blocks_done;
		logic [7:0]  attempt_count;
	} out_word_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

[rtl/core/xmodem_receiver.sv]
// xmodem receiver engine: result word valid in the cycle after word accepted
// throughput one word per cycle unless stalled; the payload memory read and the
// control update both finish in the accept cycle and land in the output stage
// arst_n clears control state, registers mode=1 and max_errors=10
// payload memory is not cleared; reads of never-written entries are undefined
module xmodem_receiver (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  xmr_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output xmr_pkg::out_word_t out_word,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import xmr_pkg::*;

	// phase codes
	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_HEADER  = 4'd1;
	localparam logic [3:0] PH_NUM     = 4'd2;
	localparam logic [3:0] PH_NUMC    = 4'd3;
	localparam logic [3:0] PH_DATA    = 4'd4;
	localparam logic [3:0] PH_CRCHI   = 4'd5;
	localparam logic [3:0] PH_CHECK   = 4'd6;
	localparam logic [3:0] PH_DISCARD = 4'd7;

	// configuration registers
	logic [1:0] mode_q;
	logic [7:0] max_err_q;

	// session control state
	logic [3:0]       phase_q;
	logic [7:0]       exp_blk_q;
	logic [15:0]      blk_total_q;
	logic [7:0]       attempts_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       hdr_num_q;
	logic [15:0]      crc_q;
	logic [7:0]       sum_q;
	logic [7:0]       crc_hi_q;
	logic [7:0]       pend_q;
	logic             good_q;
	logic [1:0]       run_mode_q;
	logic [2:0]       sess_q;

	// next-state values
	logic [3:0]       phase_n;
	logic [7:0]       exp_blk_n;
	logic [15:0]      blk_total_n;
	logic [7:0]       attempts_n;
	logic [POS_W-1:0] pos_n;
	logic [7:0]       hdr_num_n;
	logic [15:0]      crc_n;
	logic [7:0]       sum_n;
	logic [7:0]       crc_hi_n;
	logic [7:0]       pend_n;
	logic             good_n;
	logic [1:0]       run_mode_n;
	logic [2:0]       sess_n;
	logic             tx_v_n;
	logic [7:0]       tx_b_n;
	logic             wr_en;

	// payload memory, one write and one registered read per cycle, on accepted words only
	logic [7:0] pay_mem [MAX_BLOCK_BYTES];
	logic [7:0] rd_data_s1;
	logic       rd_sel_s1;

	// output stage
	logic      out_valid_q;
	out_word_t out_s1;

	logic accept;
	logic [POS_W-1:0] bsize;
	logic             crc_on;
	logic [POS_W-1:0] pos_inc;
	logic [7:0]       start_reply;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 2'd1;
			max_err_q <= 8'd10;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:   mode_q <= cfg_data[1:0];
				REG_MAXERR: max_err_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign bsize       = (run_mode_q == MODE_1K) ? POS_W'(MAX_BLOCK_BYTES) : POS_W'(128);
	assign crc_on      = (run_mode_q != MODE_SUM);
	assign pos_inc     = pos_q + POS_W'(1);
	assign start_reply = (mode_q != MODE_SUM) ? CH_C : CH_NAK;

	// per-word control update; attempt check sits where the header wait begins
	always_comb begin
		logic go_top;
		go_top      = 1'b0;
		phase_n     = phase_q;
		exp_blk_n   = exp_blk_q;
		blk_total_n = blk_total_q;
		attempts_n  = attempts_q;
		pos_n       = pos_q;
		hdr_num_n   = hdr_num_q;
		crc_n       = crc_q;
		sum_n       = sum_q;
		crc_hi_n    = crc_hi_q;
		pend_n      = pend_q;
		good_n      = good_q;
		run_mode_n  = run_mode_q;
		sess_n      = sess_q;
		tx_v_n      = 1'b0;
		tx_b_n      = 8'h00;
		wr_en       = 1'b0;

		case (in_word.action)
			ACT_START: begin
				run_mode_n  = mode_q;
				exp_blk_n   = 8'd1;
				blk_total_n = 16'd1;
				attempts_n  = 8'd0;
				pos_n       = '0;
				good_n      = 1'b0;
				sess_n      = SS_RUN;
				tx_v_n      = 1'b1;
				tx_b_n      = start_reply;
				go_top      = 1'b1;
			end
			ACT_BYTE: begin
				case (phase_q)
					PH_HEADER: begin
						if (in_word.rx_byte == CH_EOT) begin
							tx_v_n  = 1'b1;
							tx_b_n  = CH_ACK;
							sess_n  = SS_OK;
							phase_n = PH_IDLE;
						end else if (in_word.rx_byte == CH_CAN) begin
							sess_n  = SS_CANCEL;
							phase_n = PH_IDLE;
						end else if (in_word.rx_byte ==
							((run_mode_q == MODE_1K) ? CH_STX : CH_SOH)) begin
							phase_n = PH_NUM;
						end else begin
							pend_n  = CH_NAK;
							phase_n = PH_DISCARD;
						end
					end
					PH_NUM: begin
						hdr_num_n = in_word.rx_byte;
						phase_n   = PH_NUMC;
					end
					PH_NUMC: begin
						if (~hdr_num_q != in_word.rx_byte) begin
							pend_n  = CH_NAK;
							phase_n = PH_DISCARD;
						end else if (hdr_num_q == exp_blk_q - 8'd1) begin
							// duplicate of the last good block
							pend_n  = CH_ACK;
							phase_n = PH_DISCARD;
						end else if (hdr_num_q != exp_blk_q) begin
							pend_n  = CH_NAK;
							phase_n = PH_DISCARD;
						end else begin
							good_n  = 1'b0;
							pos_n   = '0;
							crc_n   = 16'h0000;
							sum_n   = 8'h00;
							phase_n = PH_DATA;
						end
					end
					PH_DATA: begin
						wr_en = (pos_q < POS_W'(MAX_BLOCK_BYTES));
						crc_n = crc_step(crc_q, in_word.rx_byte);
						sum_n = sum_q + in_word.rx_byte;
						pos_n = pos_inc;
						if (pos_inc >= bsize) begin
							phase_n = crc_on ? PH_CRCHI : PH_CHECK;
						end
					end
					PH_CRCHI: begin
						crc_hi_n = in_word.rx_byte;
						phase_n  = PH_CHECK;
					end
					PH_CHECK: begin
						if (crc_on ? ({crc_hi_q, in_word.rx_byte} == crc_q)
						           : (in_word.rx_byte == sum_q)) begin
							tx_v_n      = 1'b1;
							tx_b_n      = CH_ACK;
							exp_blk_n   = exp_blk_q + 8'd1;
							blk_total_n = blk_total_q + 16'd1;
							attempts_n  = 8'd0;
							good_n      = 1'b1;
							go_top      = 1'b1;
						end else begin
							pend_n  = CH_NAK;
							phase_n = PH_DISCARD;
						end
					end
					default: ;
				endcase
			end
			ACT_WAIT: begin
				if (phase_q == PH_DISCARD) begin
					tx_v_n = 1'b1;
					tx_b_n = pend_q;
					go_top = 1'b1;
				end else if (phase_q == PH_HEADER) begin
					pend_n  = crc_on ? CH_C : CH_NAK;
					phase_n = PH_DISCARD;
				end else if (phase_q != PH_IDLE) begin
					pend_n  = CH_NAK;
					phase_n = PH_DISCARD;
				end
			end
			ACT_LOST: begin
				if (phase_q != PH_IDLE) begin
					sess_n  = SS_LOST;
					phase_n = PH_IDLE;
				end
			end
			default: ;
		endcase

		// header wait begins: fail or count an attempt
		if (go_top) begin
			if (attempts_n >= max_err_q) begin
				sess_n  = SS_ERRORS;
				phase_n = PH_IDLE;
			end else begin
				attempts_n = attempts_n + 8'd1;
				phase_n    = PH_HEADER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			exp_blk_q   <= 8'd1;
			blk_total_q <= 16'd1;
			attempts_q  <= 8'd0;
			pos_q       <= '0;
			hdr_num_q   <= 8'd0;
			crc_q       <= 16'd0;
			sum_q       <= 8'd0;
			crc_hi_q    <= 8'd0;
			pend_q      <= 8'd0;
			good_q      <= 1'b0;
			run_mode_q  <= 2'd1;
			sess_q      <= SS_RUN;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_n;
				exp_blk_q   <= exp_blk_n;
				blk_total_q <= blk_total_n;
				attempts_q  <= attempts_n;
				pos_q       <= pos_n;
				hdr_num_q   <= hdr_num_n;
				crc_q       <= crc_n;
				sum_q       <= sum_n;
				crc_hi_q    <= crc_hi_n;
				pend_q      <= pend_n;
				good_q      <= good_n;
				run_mode_q  <= run_mode_n;
				sess_q      <= sess_n;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload memory: written on data bytes, read on payload reads
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			pay_mem[pos_q[ADDR_W-1:0]] <= in_word.rx_byte;
		end
		if (accept && in_word.action == ACT_READ) begin
			rd_data_s1 <= pay_mem[in_word.read_index];
		end
	end

	// result word, read data joined from the memory output
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_sel_s1            <= (in_word.action == ACT_READ);
			out_s1.tx_valid      <= tx_v_n;
			out_s1.tx_byte       <= tx_b_n;
			out_s1.wait_long     <= (phase_n == PH_HEADER);
			out_s1.block_good    <= good_n;
			out_s1.session_state <= sess_n;
			out_s1.read_data     <= 8'h00;
			out_s1.blocks_done   <= blk_total_n - 16'd1;
			out_s1.attempt_count <= attempts_n;
		end
	end

	always_comb begin
		out_word           = out_s1;
		out_word.read_data = rd_sel_s1 ? rd_data_s1 : 8'h00;
	end

endmodule

[rtl/core/xmr_checker.sv]
module xmr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input xmr_pkg::out_word_t out_word
);
	import xmr_pkg::*;

	a_no_tx_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.tx_valid |-> out_word.tx_byte == 8'h00)
		else $error("tx_byte set without tx_valid");

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.session_state <= SS_LOST)
		else $error("session_state out of range");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled result changed");

	a_wait_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.wait_long |-> out_word.session_state == SS_RUN)
		else $error("header wait while session not running");

endmodule

bind xmodem_receiver xmr_checker u_xmr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);
